// ===== rtl/core/qnt_pkg.sv =====
// ----------------------------------------------------------------------------
// Quadtree node table package
// Shared widths, codes, state encoding and table entry layout.
// ----------------------------------------------------------------------------
package qnt_pkg;

  localparam int NODE_W  = 10;
  localparam int DEPTH_W = 5;
  localparam int SIDE_W  = 17;
  localparam int COORD_W = 16;
  localparam int COUNT_W = 11;

  localparam logic OP_SPLIT = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_INDEX = 3'd1,
    ST_FULL      = 3'd2,
    ST_SPLIT     = 3'd3,
    ST_TOO_DEEP  = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_WALK,
    S_CHILD,
    S_RESP
  } fsm_t;

  // One table entry as held in the node memory.
  typedef struct packed {
    logic [DEPTH_W-1:0] depth;
    logic [NODE_W-1:0]  parent;
    logic               split;
  } entry_t;

  // Result of one transaction.
  typedef struct packed {
    status_t             status;
    logic [COORD_W-1:0]  box_x;
    logic [COORD_W-1:0]  box_y;
    logic [SIDE_W-1:0]   size;
    logic [1:0]          quadrant;
    logic [NODE_W-1:0]   child_base;
  } result_t;

  // Position of a node under its parent. Children are always appended in
  // groups of four starting at an index of the form 4k+1.
  function automatic logic [1:0] quad_of(input logic [NODE_W-1:0] node);
    quad_of = node[1:0] - 2'd1;
  endfunction

endpackage

// ===== rtl/core/qnt_if.sv =====
// ----------------------------------------------------------------------------
// Quadtree node table channels
// Request, response and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface qnt_req_if;
  logic                       valid;
  logic                       ready;
  logic                       opcode;
  logic [qnt_pkg::NODE_W-1:0] node_index;

  modport source (output valid, opcode, node_index, input ready);
  modport sink   (input valid, opcode, node_index, output ready);
endinterface

interface qnt_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [2:0]                  status;
  logic [qnt_pkg::COORD_W-1:0] box_x;
  logic [qnt_pkg::COORD_W-1:0] box_y;
  logic [qnt_pkg::SIDE_W-1:0]  box_width;
  logic [qnt_pkg::SIDE_W-1:0]  box_height;
  logic [1:0]                  quadrant;
  logic [qnt_pkg::NODE_W-1:0]  child_base;

  modport source (output valid, status, box_x, box_y, box_width, box_height,
                  quadrant, child_base, input ready);
  modport sink   (input valid, status, box_x, box_y, box_width, box_height,
                  quadrant, child_base, output ready);
endinterface

interface qnt_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [qnt_pkg::SIDE_W-1:0] map_side;

  modport source (output valid, map_side, input ready);
  modport sink   (input valid, map_side, output ready);
endinterface

// ===== rtl/core/quadtree_node_table_core.sv =====
// ----------------------------------------------------------------------------
// Quadtree node table core
// Flat quadtree table with split and box query transactions.
// ----------------------------------------------------------------------------
// A bad index or full table answers without a memory read, an already split or
// too deep node after the read, an accepted split after read, check and mark,
// four child writes and respond, and a query after one node memory read per
// level of the parent walk. One transaction is worked on at a time; the next
// is accepted the cycle after the result has moved into the output register.
// Reset leaves only the root; the memory needs no clearing.
module quadtree_node_table_core #(
  parameter int CAPACITY  = 1024,
  parameter int MAX_DEPTH = 16
) (
  input  logic   clk,
  input  logic   rst,
  qnt_cfg_if.sink   cfg,
  qnt_req_if.sink   req,
  qnt_rsp_if.source rsp
);
  import qnt_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam logic [COUNT_W:0]    CAP_L   = (COUNT_W+1)'(CAPACITY);
  localparam logic [DEPTH_W-1:0]  DEPTH_L = DEPTH_W'(MAX_DEPTH);

  // Node memory: depth, parent and split flag of every entry. The root is
  // never written as a child, so its split flag lives in a flip-flop and its
  // depth is forced to zero whenever entry zero is read.
  entry_t mem [CAPACITY];
  entry_t rd_data;
  logic   rd_root;
  logic   rd_en;
  logic [AW-1:0] rd_addr;
  logic   wr_en;
  logic [AW-1:0] wr_addr;
  entry_t wr_data;
  entry_t ent;

  // Control state.
  fsm_t state, state_next;
  logic [COUNT_W-1:0] used_count, used_count_next;
  logic root_split, root_split_next;
  logic [SIDE_W-1:0] map_side;
  logic rsp_valid, rsp_valid_next;

  // Working registers of the current transaction.
  logic op, op_next;
  logic [NODE_W-1:0] node, node_next;
  logic [NODE_W-1:0] cur, cur_next;
  logic [DEPTH_W-1:0] child_depth, child_depth_next;
  logic [1:0] k, k_next;
  result_t res, res_next;
  result_t out_res, out_res_next;

  // Helpers.
  logic [SIDE_W-1:0] half;
  logic [1:0]        q;
  logic [COUNT_W-1:0] child_idx;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
      rd_root <= (rd_addr == '0);
    end
  end

  always_comb begin
    ent = rd_data;
    if (rd_root) begin
      ent.depth  = '0;
      ent.parent = '0;
      ent.split  = root_split;
    end
  end

  // Configuration writes are taken whenever the core is out of reset; the
  // contract keeps them to idle periods.
  assign cfg.ready = ~rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_side <= SIDE_W'(1024);
    end else if (cfg.valid) begin
      map_side <= cfg.map_side;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      used_count <= COUNT_W'(1);
      root_split <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      used_count <= used_count_next;
      root_split <= root_split_next;
      rsp_valid  <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    op          <= op_next;
    node        <= node_next;
    cur         <= cur_next;
    child_depth <= child_depth_next;
    k           <= k_next;
    res         <= res_next;
    out_res     <= out_res_next;
  end

  assign half      = map_side >> ent.depth;
  assign q         = quad_of(cur);
  assign child_idx = used_count + COUNT_W'(k);

  always_comb begin
    state_next       = state;
    used_count_next  = used_count;
    root_split_next  = root_split;
    rsp_valid_next   = rsp_valid & ~rsp.ready;
    op_next          = op;
    node_next        = node;
    cur_next         = cur;
    child_depth_next = child_depth;
    k_next           = k;
    res_next         = res;
    out_res_next     = out_res;
    rd_en            = 1'b0;
    rd_addr          = node[AW-1:0];
    wr_en            = 1'b0;
    wr_addr          = node[AW-1:0];
    wr_data          = ent;
    req.ready        = 1'b0;

    case (state)
      S_IDLE: begin
        req.ready = ~rst;
        if (req.valid) begin
          op_next   = req.opcode;
          node_next = req.node_index;
          res_next  = '0;
          if ({1'b0, req.node_index} >= used_count) begin
            res_next.status = ST_BAD_INDEX;
            state_next      = S_RESP;
          end else if (req.opcode == OP_SPLIT &&
                       ({1'b0, used_count} + (COUNT_W+1)'(4)) > CAP_L) begin
            res_next.status = ST_FULL;
            state_next      = S_RESP;
          end else begin
            rd_en      = 1'b1;
            rd_addr    = req.node_index[AW-1:0];
            state_next = S_FETCH;
          end
        end
      end

      S_FETCH: begin
        if (op == OP_SPLIT) begin
          if (ent.split) begin
            res_next.status = ST_SPLIT;
            state_next      = S_RESP;
          end else if (ent.depth >= DEPTH_L) begin
            res_next.status = ST_TOO_DEEP;
            state_next      = S_RESP;
          end else begin
            // Mark the node as split in the same cycle as the checks.
            wr_en         = 1'b1;
            wr_data.split = 1'b1;
            if (node == '0) begin
              root_split_next = 1'b1;
            end
            child_depth_next = ent.depth + DEPTH_W'(1);
            k_next           = '0;
            state_next       = S_CHILD;
          end
        end else begin
          // The read data is held, so the walk starts on this same entry.
          res_next.size     = half;
          res_next.quadrant = (ent.depth != '0) ? quad_of(node) : 2'd0;
          cur_next          = node;
          state_next        = S_WALK;
        end
      end

      S_WALK: begin
        if (ent.depth == '0) begin
          state_next = S_RESP;
        end else begin
          if (q[1]) begin
            res_next.box_x = res.box_x + half[COORD_W-1:0];
          end
          if (q[1] ^ q[0]) begin
            res_next.box_y = res.box_y + half[COORD_W-1:0];
          end
          cur_next = ent.parent;
          rd_en    = 1'b1;
          rd_addr  = ent.parent[AW-1:0];
        end
      end

      S_CHILD: begin
        wr_en          = 1'b1;
        wr_addr        = child_idx[AW-1:0];
        wr_data.depth  = child_depth;
        wr_data.parent = node;
        wr_data.split  = 1'b0;
        k_next         = k + 2'd1;
        if (k == 2'd3) begin
          res_next.child_base = used_count[NODE_W-1:0];
          used_count_next     = used_count + COUNT_W'(4);
          state_next          = S_RESP;
        end
      end

      S_RESP: begin
        if (!rsp_valid || rsp.ready) begin
          rsp_valid_next = 1'b1;
          out_res_next   = res;
          state_next     = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign rsp.valid      = rsp_valid;
  assign rsp.status     = out_res.status;
  assign rsp.box_x      = out_res.box_x;
  assign rsp.box_y      = out_res.box_y;
  assign rsp.box_width  = out_res.size;
  assign rsp.box_height = out_res.size;
  assign rsp.quadrant   = out_res.quadrant;
  assign rsp.child_base = out_res.child_base;

endmodule
